// ===== hw/rtl/mrt_pkg.sv =====
package mrt_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int SCORE_W         = 13;
	localparam int SCORE_BASE      = 10;
	localparam int RELAY_SCALE     = 243;
	localparam int HOPS_MAX        = 15;
	localparam int PURGE_MAX       = 31;
	localparam logic [31:0] TIMEOUT_RST = 32'd300000;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_RELAY  = 3'd1,
		OP_REMOVE = 3'd2,
		OP_LOOKUP = 3'd3,
		OP_PURGE  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_WORSE     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4,
		ST_DISABLED  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		REG_ENABLED = 2'd0,
		REG_OWN_ID  = 2'd1,
		REG_TIMEOUT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] destination;
		logic [31:0] next_hop;
		logic [3:0]  hop_count;
		logic [7:0]  reliability;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] found_next_hop;
		logic [3:0]  found_hop_count;
		logic [7:0]  found_reliability;
		logic [4:0]  purged_count;
	} rsp_t;

	typedef struct packed {
		logic [31:0]               destination;
		logic [31:0]               next_hop;
		logic [3:0]                hops;
		logic [7:0]                reliability;
		logic [31:0]               last_used;
		logic signed [SCORE_W-1:0] score;
	} entry_t;

	function automatic logic signed [SCORE_W-1:0] route_score(logic [7:0] rel,
			logic [3:0] hops);
		logic signed [8:0]  rel_s;
		logic signed [4:0]  dist_s;
		logic signed [13:0] prod;
		rel_s  = $signed({1'b0, rel});
		dist_s = $signed(5'(SCORE_BASE)) - $signed({1'b0, hops});
		prod   = 14'(rel_s * dist_s);
		return prod[SCORE_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/mesh_route_table.sv =====
// Channel   Handshake          Payload             Transaction at
// request   start / busy       req                 rising edge with start high, busy low
// result    done (strobe)      rsp                 rising edge ending the done cycle
// config    wr_en              wr_index, wr_data   rising edge with wr_en high
//
// One operation per cycle: busy stays low and a request is taken every cycle.
// The result is registered at the edge after the accepting edge and is on rsp for
// the cycle that follows: input register, then one pass through the parallel
// destination compare, slot priority and score compare.
// Reset clears all valid bits at once; no clearing pass is needed.
// The receiver cannot stall; each result is shown for exactly one cycle.
module mesh_route_table #(
	parameter int TABLE_DEPTH = mrt_pkg::TABLE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mrt_pkg::req_t req,
	output logic          done,
	output mrt_pkg::rsp_t rsp,
	input  logic          wr_en,
	input  logic [1:0]    wr_index,
	input  logic [31:0]   wr_data
);
	import mrt_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic        enabled_q;
	logic [31:0] own_id_q;
	logic [31:0] timeout_q;

	logic        valid_s1;
	req_t        req_s1;

	req_t        req_in;
	logic [15:0] relay_prod;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TABLE_DEPTH-1:0] valid_d;
	entry_t                 tbl_q [TABLE_DEPTH];

	logic [TABLE_DEPTH-1:0] match;
	logic [TABLE_DEPTH-1:0] stale;
	logic                   hit;
	logic                   free_any;
	logic [IDX_W-1:0]       match_idx;
	logic [IDX_W-1:0]       free_idx;
	logic [CNT_W-1:0]       stale_cnt;
	logic signed [SCORE_W-1:0] new_score;

	logic                   upd;
	logic [IDX_W-1:0]       upd_idx;
	logic                   refresh;
	logic [TABLE_DEPTH-1:0] clr;
	rsp_t                   rsp_d;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			own_id_q  <= '0;
			timeout_q <= TIMEOUT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_ENABLED: enabled_q <= wr_data[0];
				REG_OWN_ID:  own_id_q  <= wr_data;
				REG_TIMEOUT: timeout_q <= wr_data;
				default: ;
			endcase
		end
	end

	// apply relay hop and reliability scaling on the way in
	always_comb begin
		relay_prod = 16'(req.reliability * 8'(RELAY_SCALE));
		req_in     = req;
		if (req.op == OP_RELAY) begin
			req_in.hop_count = (req.hop_count == 4'(HOPS_MAX)) ? 4'(HOPS_MAX) :
				req.hop_count + 4'd1;
			req_in.reliability = relay_prod[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req_in;
		end
	end

	always_comb begin
		match_idx = '0;
		free_idx  = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (tbl_q[i].destination == req_s1.destination);
			stale[i] = valid_q[i] && ((req_s1.now_ms - tbl_q[i].last_used) > timeout_q);
			if (match[i]) match_idx = IDX_W'(i);
			if (!valid_q[i]) free_idx = IDX_W'(i);
		end
		hit       = |match;
		free_any  = !(&valid_q);
		stale_cnt = CNT_W'($countones(stale));
		new_score = route_score(req_s1.reliability, req_s1.hop_count);
	end

	always_comb begin
		rsp_d        = '0;
		rsp_d.status = ST_OK;
		upd          = 1'b0;
		upd_idx      = match_idx;
		refresh      = 1'b0;
		clr          = '0;
		if (!enabled_q) begin
			rsp_d.status = ST_DISABLED;
		end else begin
			case (req_s1.op)
				OP_ADD, OP_RELAY: begin
					if (req_s1.destination == own_id_q || req_s1.next_hop == '0) begin
						rsp_d.status = ST_INVALID;
					end else if (hit) begin
						if (new_score <= tbl_q[match_idx].score) begin
							rsp_d.status = ST_WORSE;
						end else begin
							upd = 1'b1;
						end
					end else if (free_any) begin
						upd     = 1'b1;
						upd_idx = free_idx;
					end else begin
						rsp_d.status = ST_FULL;
					end
				end
				OP_REMOVE: begin
					if (hit) begin
						clr[match_idx] = 1'b1;
					end else begin
						rsp_d.status = ST_NOT_FOUND;
					end
				end
				OP_LOOKUP: begin
					if (hit) begin
						refresh                 = 1'b1;
						rsp_d.found_next_hop    = tbl_q[match_idx].next_hop;
						rsp_d.found_hop_count   = tbl_q[match_idx].hops;
						rsp_d.found_reliability = tbl_q[match_idx].reliability;
					end else begin
						rsp_d.status = ST_NOT_FOUND;
					end
				end
				OP_PURGE: begin
					clr = stale;
					rsp_d.purged_count = (32'(stale_cnt) > 32'(PURGE_MAX)) ?
						5'(PURGE_MAX) : 5'(stale_cnt);
				end
				default: rsp_d.status = ST_INVALID;
			endcase
		end
	end

	always_comb begin
		valid_d = valid_q & ~clr;
		if (upd) valid_d[upd_idx] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= valid_s1;
			if (valid_s1) begin
				valid_q <= valid_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp <= rsp_d;
			if (upd) begin
				tbl_q[upd_idx].destination <= req_s1.destination;
				tbl_q[upd_idx].next_hop    <= req_s1.next_hop;
				tbl_q[upd_idx].hops        <= req_s1.hop_count;
				tbl_q[upd_idx].reliability <= req_s1.reliability;
				tbl_q[upd_idx].last_used   <= req_s1.now_ms;
				tbl_q[upd_idx].score       <= new_score;
			end else if (refresh) begin
				tbl_q[match_idx].last_used <= req_s1.now_ms;
			end
		end
	end

`ifndef SYNTHESIS
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("result strobe missing after a transaction");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> !done)
		else $error("result strobe without a transaction");

	a_table_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1 || !enabled_q) |=> $stable(valid_q))
		else $error("table changed without an enabled transaction");

	a_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (rsp.found_next_hop == '0 &&
			rsp.purged_count == '0))
		else $error("result fields set on a failed transaction");
`endif

endmodule
